[rtl/rbd_pkg.sv]
`default_nettype none

package rbd_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	localparam int CMD_W   = 3;
	localparam int WORD_W  = 32;
	localparam int POS_W   = 4;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Depth of the queue between the front and the back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [2:0] {
		KIND_NOP,
		KIND_PUSH,
		KIND_POP,
		KIND_PEEK,
		KIND_READ
	} kind_t;

	// A classified request as it travels from the front to the back.
	typedef struct packed {
		kind_t              kind;
		logic               at_back;
		data_t              data;
		logic [POS_W-1:0]   position;
	} item_t;

endpackage

`default_nettype wire

[rtl/rbd_cmd_if.sv]
`default_nettype none

interface rbd_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [rbd_pkg::CMD_W-1:0]   command;
	logic [rbd_pkg::WORD_W-1:0]  data_in;
	logic [rbd_pkg::POS_W-1:0]   position;

	modport source(output valid, command, data_in, position, input ready);
	modport sink(input valid, command, data_in, position, output ready);
endinterface

`default_nettype wire

[rtl/rbd_rsp_if.sv]
`default_nettype none

interface rbd_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rbd_pkg::WORD_W-1:0]   data_out;
	logic [rbd_pkg::STAT_W-1:0]   status;
	logic [rbd_pkg::COUNT_W-1:0]  entry_count;
	logic                         is_empty;
	logic                         is_full;

	modport source(output valid, data_out, status, entry_count, is_empty, is_full,
		input ready);
	modport sink(input valid, data_out, status, entry_count, is_empty, is_full,
		output ready);
endinterface

`default_nettype wire

[rtl/rbd_front.sv]
`default_nettype none

module rbd_front (
	rbd_cmd_if.sink         cmd,
	output logic            q_valid,
	input  logic            q_ready,
	output rbd_pkg::item_t  q_item
);

	assign q_valid = cmd.valid;
	assign cmd.ready = q_ready;

	always_comb begin
		q_item.kind     = rbd_pkg::KIND_NOP;
		q_item.at_back  = 1'b0;
		q_item.data     = cmd.data_in[rbd_pkg::DATA_W-1:0];
		q_item.position = cmd.position;
		unique case (cmd.command)
			rbd_pkg::CMD_PUSH_FRONT: begin
				q_item.kind = rbd_pkg::KIND_PUSH;
			end
			rbd_pkg::CMD_PUSH_BACK: begin
				q_item.kind    = rbd_pkg::KIND_PUSH;
				q_item.at_back = 1'b1;
			end
			rbd_pkg::CMD_POP_FRONT: begin
				q_item.kind = rbd_pkg::KIND_POP;
			end
			rbd_pkg::CMD_POP_BACK: begin
				q_item.kind    = rbd_pkg::KIND_POP;
				q_item.at_back = 1'b1;
			end
			rbd_pkg::CMD_PEEK_FRONT: begin
				q_item.kind = rbd_pkg::KIND_PEEK;
			end
			rbd_pkg::CMD_PEEK_BACK: begin
				q_item.kind    = rbd_pkg::KIND_PEEK;
				q_item.at_back = 1'b1;
			end
			rbd_pkg::CMD_READ_AT: begin
				q_item.kind = rbd_pkg::KIND_READ;
			end
			default: begin
				// The unused code passes through as a request with no effect.
				q_item.kind = rbd_pkg::KIND_NOP;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/rbd_queue.sv]
`default_nettype none

module rbd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rbd_pkg::item_t  in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output rbd_pkg::item_t  out_item
);

	rbd_pkg::item_t                ent_q [rbd_pkg::Q_DEPTH];
	logic [rbd_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [rbd_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [rbd_pkg::Q_CNT_W-1:0]   cnt_q;
	logic                          push;
	logic                          pop;

	assign in_ready  = cnt_q != rbd_pkg::Q_CNT_W'(rbd_pkg::Q_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_item  = ent_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == rbd_pkg::Q_PTR_W'(rbd_pkg::Q_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == rbd_pkg::Q_PTR_W'(rbd_pkg::Q_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/rbd_back.sv]
`default_nettype none

module rbd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  rbd_pkg::item_t  q_item,
	rbd_rsp_if.source       rsp
);

	rbd_pkg::data_t               mem_q [rbd_pkg::DEPTH];
	rbd_pkg::ptr_t                head_q;
	rbd_pkg::ptr_t                tail_q;
	rbd_pkg::cnt_t                count_q;

	rbd_pkg::ptr_t                head_n;
	rbd_pkg::ptr_t                tail_n;
	rbd_pkg::cnt_t                count_n;
	logic [rbd_pkg::STAT_W-1:0]   status_n;
	logic                         wr_en;
	logic                         rd_en;
	rbd_pkg::ptr_t                wr_addr;
	rbd_pkg::ptr_t                rd_addr;
	logic                         full;
	logic                         empty;
	logic                         exec;

	logic                         valid_s2;
	logic                         rd_s2;
	logic [rbd_pkg::STAT_W-1:0]   status_s2;
	rbd_pkg::cnt_t                count_s2;
	rbd_pkg::data_t               rdata_s2;

	assign full    = count_q == rbd_pkg::CNT_W'(rbd_pkg::DEPTH);
	assign empty   = count_q == '0;
	assign q_ready = !valid_s2 || rsp.ready;
	assign exec    = q_valid && q_ready;

	// The store depth is a power of two, so pointers wrap by plain overflow.
	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		count_n  = count_q;
		status_n = rbd_pkg::ST_OK;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = q_item.at_back ? tail_q + 1'b1 : head_q - 1'b1;
		rd_addr  = q_item.at_back ? tail_q : head_q;
		unique case (q_item.kind)
			rbd_pkg::KIND_PUSH: begin
				if (full) begin
					status_n = rbd_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					count_n = count_q + 1'b1;
					if (q_item.at_back) begin
						tail_n = wr_addr;
					end else begin
						head_n = wr_addr;
					end
				end
			end
			rbd_pkg::KIND_POP: begin
				if (empty) begin
					status_n = rbd_pkg::ST_EMPTY;
				end else begin
					count_n = count_q - 1'b1;
					if (q_item.at_back) begin
						tail_n = tail_q - 1'b1;
					end else begin
						head_n = head_q + 1'b1;
					end
				end
			end
			rbd_pkg::KIND_PEEK: begin
				if (empty) begin
					status_n = rbd_pkg::ST_EMPTY;
				end else begin
					rd_en = 1'b1;
				end
			end
			rbd_pkg::KIND_READ: begin
				rd_addr = head_q + rbd_pkg::PTR_W'(q_item.position);
				if (rbd_pkg::CNT_W'(q_item.position) >= count_q) begin
					status_n = rbd_pkg::ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// A read and a write never belong to the same request, so a read always
	// sees the writes of all earlier requests.
	always_ff @(posedge clk) begin
		if (exec && wr_en) begin
			mem_q[wr_addr] <= q_item.data;
		end
		if (exec && rd_en) begin
			rdata_s2 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rd_s2     <= rd_en;
			status_s2 <= status_n;
			count_s2  <= count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= rbd_pkg::PTR_W'(rbd_pkg::DEPTH - 1);
			count_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (exec) begin
				head_q   <= head_n;
				tail_q   <= tail_n;
				count_q  <= count_n;
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.data_out    = rd_s2 ? rbd_pkg::word_t'(rdata_s2) : '0;
	assign rsp.status      = status_s2;
	assign rsp.entry_count = rbd_pkg::COUNT_W'(count_s2);
	assign rsp.is_empty    = count_s2 == '0;
	assign rsp.is_full     = count_s2 == rbd_pkg::CNT_W'(rbd_pkg::DEPTH);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rbd_pkg::CNT_W'(rbd_pkg::DEPTH))
		else $error("entry count exceeds the store depth");

	a_ptr_span: assert property (@(posedge clk) disable iff (!arst_n)
		rbd_pkg::ptr_t'(tail_q - head_q + 1'b1) == count_q[rbd_pkg::PTR_W-1:0])
		else $error("head and tail pointers disagree with the entry count");

	a_refused_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		exec && status_n != rbd_pkg::ST_OK |=>
		$stable(count_q) && $stable(head_q) && $stable(tail_q))
		else $error("refused request changed the queue state");

	a_read_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rd_s2 |-> status_s2 == rbd_pkg::ST_OK)
		else $error("read data returned with a failing status");

endmodule

`default_nettype wire

[rtl/ring_buffer_deque.sv]
// Double-ended queue over a 16-word circular store.
// Path: a request is queued, then executed by the back, which registers its response.
// Throughput: the back executes one request per cycle while rsp.ready is high, and a
// two-entry queue between the decoder and the back absorbs output stalls.
// Reset: asynchronous, active low; empty queue, head at zero, tail at DEPTH-1.
// The store itself is not cleared; entries are only read after being written.
`default_nettype none

module ring_buffer_deque (
	input  logic       clk,
	input  logic       arst_n,
	rbd_cmd_if.sink    cmd,
	rbd_rsp_if.source  rsp
);

	logic            fq_valid;
	logic            fq_ready;
	rbd_pkg::item_t  fq_item;
	logic            qb_valid;
	logic            qb_ready;
	rbd_pkg::item_t  qb_item;

	rbd_front u_front (
		.cmd     (cmd),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_item  (fq_item)
	);

	rbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	rbd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (qb_valid),
		.q_ready (qb_ready),
		.q_item  (qb_item),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire
